>>> rtl/cpa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Chunk pool allocator package
// Shared widths, operation and status codes, register indexes and the
// command/status structs between the controller and the datapath.
// ----------------------------------------------------------------------------
package cpa_pkg;

    localparam int IDX_W      = 10;
    localparam int COUNT_W    = 11;
    localparam int BYTES_W    = 17;
    localparam int OFF_W      = 26;
    localparam int FUNC_W     = 2;
    localparam int STATUS_W   = 2;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 17;

    localparam int LINK_W  = IDX_W + 1;
    localparam int SPILL_W = COUNT_W + LINK_W;

    localparam int MAX_CHUNKS_DEF  = 1024;
    localparam int CHUNK_COUNT_RST = 1024;
    localparam int CHUNK_BYTES_RST = 64;

    localparam logic [FUNC_W-1:0] FUNC_ALLOC = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_FREE  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_REJECT = 2'd2;

    localparam logic [CFG_ADDR_W-1:0] REG_CHUNK_COUNT = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_CHUNK_BYTES = 1'b1;

    // Threshold percentages and reciprocal constants:
    // floor(x/100) = (x * RECIP_100) >> 24 for x < 199728
    // floor(x/10)  = (x * RECIP_10)  >> 20 for x < 262144
    localparam int DANGER_PCT  = 95;
    localparam int SAFE_TENTHS = 9;
    localparam int P95_W       = COUNT_W + 7;
    localparam int P9_W        = COUNT_W + 4;
    localparam int R100_W      = 18;
    localparam int R10_W       = 17;
    localparam logic [R100_W-1:0] RECIP_100 = 18'd167773;
    localparam logic [R10_W-1:0]  RECIP_10  = 17'd104858;
    localparam int SHIFT_100   = 24;
    localparam int SHIFT_10    = 20;

    typedef struct packed {
        logic capture;
        logic exec;
        logic load;
    } ctl_cmd_t;

    typedef struct packed {
        logic out_room;
        logic needs_load;
        logic reinit;
    } dp_stat_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [IDX_W-1:0]    chunk_index;
        logic [OFF_W-1:0]    chunk_offset;
        logic [COUNT_W-1:0]  free_count;
        logic [COUNT_W-1:0]  danger_excess;
    } result_t;

endpackage

>>> rtl/cpa_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Chunk pool allocator channels
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface cpa_req_if;
    import cpa_pkg::*;

    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [IDX_W-1:0]  free_index;

    modport source (output valid, output func, output free_index, input ready);
    modport sink   (input valid, input func, input free_index, output ready);
endinterface

interface cpa_rsp_if;
    import cpa_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [IDX_W-1:0]    chunk_index;
    logic [OFF_W-1:0]    chunk_offset;
    logic [COUNT_W-1:0]  free_count;
    logic [COUNT_W-1:0]  danger_excess;

    modport source (output valid, output status, output chunk_index, output chunk_offset,
                    output free_count, output danger_excess, input ready);
    modport sink   (input valid, input status, input chunk_index, input chunk_offset,
                    input free_count, input danger_excess, output ready);
endinterface

>>> rtl/chunk_pool_allocator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Chunk pool allocator
// Fixed-size chunk pool with a LIFO free list of runs of free chunks.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one operation per transaction: allocate, free or status
//   query. rsp returns exactly one result per request: status, allocated
//   index and byte offset, free count and danger excess.
//   The cfg port writes chunk_count (index 0, reinitializes the pool as
//   one run) and chunk_bytes (index 1); write only while the block is idle.
//   An accepted request is captured into a register, then executed into
//   the result register; rsp.valid rises when that register loads.
//   req is ready again only after capture and execute; an allocate that
//   empties the head run and follows a link adds a load step, bounded by
//   the registered read of the spill memory. After a chunk_count write, req
//   is held off while the usage thresholds are recomputed.
//   The result sits in an output register; a new request is accepted while
//   it waits, and execution holds until rsp is taken.
//   Reset restores chunk_count 1024 (clamped to MAX_CHUNKS), chunk_bytes
//   64 and a full pool; spill memory contents need no clearing.
// ----------------------------------------------------------------------------
module chunk_pool_allocator_top #(
    parameter int MAX_CHUNKS = cpa_pkg::MAX_CHUNKS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [cpa_pkg::CFG_ADDR_W-1:0] cfg_index,
    input  logic [cpa_pkg::CFG_DATA_W-1:0] cfg_data,
    cpa_req_if.sink                        req,
    cpa_rsp_if.source                      rsp
);
    import cpa_pkg::*;

    ctl_cmd_t cmd;
    dp_stat_t stat;
    result_t  res;

    cpa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    cpa_datapath #(
        .MAX_CHUNKS (MAX_CHUNKS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .req_func       (req.func),
        .req_free_index (req.free_index),
        .cmd            (cmd),
        .stat           (stat),
        .rsp_ready      (rsp.ready),
        .rsp_valid      (rsp.valid),
        .rsp_data       (res)
    );

    assign rsp.status        = res.status;
    assign rsp.chunk_index   = res.chunk_index;
    assign rsp.chunk_offset  = res.chunk_offset;
    assign rsp.free_count    = res.free_count;
    assign rsp.danger_excess = res.danger_excess;

endmodule

>>> rtl/cpa_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port, registered read data.
// ----------------------------------------------------------------------------
module cpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> rtl/cpa_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Chunk pool allocator controller
// Sequences capture, execute and spill load; blocks requests while the
// thresholds settle after a chunk count write.
// ----------------------------------------------------------------------------
module cpa_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  cpa_pkg::dp_stat_t stat,
    output cpa_pkg::ctl_cmd_t cmd
);
    import cpa_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_LOAD
    } state_t;

    state_t     state_reg;
    state_t     state_next;
    logic [1:0] settle_reg;
    logic [1:0] settle_next;

    assign req_ready = (state_reg == ST_IDLE) && (settle_reg == 2'd0);

    always_comb
    begin
        cmd         = '0;
        state_next  = state_reg;
        settle_next = settle_reg;
        if (stat.reinit)
        begin
            settle_next = 2'd2;
        end
        else if (settle_reg != 2'd0)
        begin
            settle_next = settle_reg - 2'd1;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid && req_ready)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                // hold until the result register can take the transaction
                if (stat.out_room)
                begin
                    cmd.exec   = 1'b1;
                    state_next = stat.needs_load ? ST_LOAD : ST_IDLE;
                end
            end
            ST_LOAD:
            begin
                cmd.load   = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            settle_reg <= 2'd0;
        end
        else
        begin
            state_reg  <= state_next;
            settle_reg <= settle_next;
        end
    end

endmodule

>>> rtl/cpa_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Chunk pool allocator datapath
// Head run registers, free count, spill memory, thresholds and the
// result register.
// ----------------------------------------------------------------------------
module cpa_datapath #(
    parameter int MAX_CHUNKS = cpa_pkg::MAX_CHUNKS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [cpa_pkg::CFG_ADDR_W-1:0]   cfg_index,
    input  logic [cpa_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic [cpa_pkg::FUNC_W-1:0]       req_func,
    input  logic [cpa_pkg::IDX_W-1:0]        req_free_index,
    input  cpa_pkg::ctl_cmd_t                cmd,
    output cpa_pkg::dp_stat_t                stat,
    input  logic                             rsp_ready,
    output logic                             rsp_valid,
    output cpa_pkg::result_t                 rsp_data
);
    import cpa_pkg::*;

    localparam int ADDR_W  = $clog2(MAX_CHUNKS);
    localparam int CC_RST  = (CHUNK_COUNT_RST > MAX_CHUNKS) ? MAX_CHUNKS : CHUNK_COUNT_RST;
    localparam int DNG_RST = CC_RST * DANGER_PCT / 100;
    localparam int SAF_RST = CC_RST * SAFE_TENTHS / 10;

    logic [COUNT_W-1:0] cc_reg;
    logic [BYTES_W-1:0] bytes_reg;
    logic [IDX_W-1:0]   head_index_reg;
    logic [COUNT_W-1:0] head_run_reg;
    logic [LINK_W-1:0]  head_link_reg;
    logic [COUNT_W-1:0] free_reg;
    logic [P95_W-1:0]   p95_reg;
    logic [P9_W-1:0]    p9_reg;
    logic [COUNT_W-1:0] danger_thr_reg;
    logic [COUNT_W-1:0] safe_thr_reg;
    logic               out_valid_reg;
    result_t            out_reg;
    logic [FUNC_W-1:0]  func_reg;
    logic [IDX_W-1:0]   fidx_reg;

    logic [P95_W+R100_W-1:0]  m100;
    logic [P9_W+R10_W-1:0]    m10;
    logic [COUNT_W-1:0]       cc_wr;
    logic [COUNT_W-1:0]       run_eff;
    logic                     is_alloc;
    logic                     is_free;
    logic                     pool_empty;
    logic                     run_more;
    logic                     link_null;
    logic                     alloc_ok;
    logic                     free_ok;
    logic [IDX_W:0]           idx_inc;
    logic [IDX_W-1:0]         idx_step;
    logic [COUNT_W-1:0]       free_next;
    logic [COUNT_W-1:0]       used;
    logic [IDX_W+BYTES_W-1:0] offset_full;
    result_t                  res;
    logic                     ram_we;
    logic                     ram_re;
    logic [SPILL_W-1:0]       ram_wdata;
    logic [SPILL_W-1:0]       ram_rdata;

    // Clamp a chunk count write into 1..MAX_CHUNKS
    always_comb
    begin
        cc_wr = cfg_data[COUNT_W-1:0];
        if (cc_wr == '0)
        begin
            cc_wr = COUNT_W'(1);
        end
        else if (32'(cc_wr) > MAX_CHUNKS)
        begin
            cc_wr = COUNT_W'(MAX_CHUNKS);
        end
    end

    assign m100 = p95_reg * RECIP_100;
    assign m10  = p9_reg * RECIP_10;

    assign run_eff    = (head_run_reg == '0) ? COUNT_W'(1) : head_run_reg;
    assign is_alloc   = (func_reg == FUNC_ALLOC);
    assign is_free    = (func_reg == FUNC_FREE);
    assign pool_empty = (free_reg == '0);
    assign run_more   = (run_eff > COUNT_W'(1));
    assign link_null  = head_link_reg[LINK_W-1];
    assign alloc_ok   = is_alloc && !pool_empty;
    assign free_ok    = is_free && ({1'b0, fidx_reg} < cc_reg) && (free_reg < cc_reg);
    assign idx_inc    = {1'b0, head_index_reg} + 1'b1;
    assign idx_step   = (32'(idx_inc) >= MAX_CHUNKS) ? '0 : idx_inc[IDX_W-1:0];
    assign offset_full = head_index_reg * bytes_reg;

    always_comb
    begin
        free_next = free_reg;
        if (alloc_ok)
        begin
            free_next = free_reg - 1'b1;
        end
        else if (free_ok)
        begin
            free_next = free_reg + 1'b1;
        end
        used = (cc_reg >= free_next) ? (cc_reg - free_next) : '0;

        res               = '0;
        res.free_count    = free_next;
        res.danger_excess = (used > danger_thr_reg) ? (used - safe_thr_reg) : '0;
        if (is_alloc)
        begin
            if (pool_empty)
            begin
                res.status = STATUS_EMPTY;
            end
            else
            begin
                res.chunk_index  = head_index_reg;
                res.chunk_offset = offset_full[OFF_W-1:0];
            end
        end
        else if (is_free && !free_ok)
        begin
            res.status = STATUS_REJECT;
        end
    end

    // Spill the old head when a free pushes a new one-chunk run
    assign ram_we    = cmd.exec && free_ok && !pool_empty;
    assign ram_wdata = {run_eff - 1'b1, head_link_reg};
    assign ram_re    = cmd.exec && stat.needs_load;

    cpa_ram #(
        .WIDTH (SPILL_W),
        .DEPTH (MAX_CHUNKS)
    ) u_spill (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ADDR_W'(head_index_reg)),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ADDR_W'(head_link_reg[IDX_W-1:0])),
        .rdata (ram_rdata)
    );

    assign stat.out_room   = !out_valid_reg || rsp_ready;
    assign stat.needs_load = alloc_ok && !run_more && !link_null;
    assign stat.reinit     = cfg_we && (cfg_index == REG_CHUNK_COUNT);

    assign rsp_valid = out_valid_reg;
    assign rsp_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cc_reg         <= COUNT_W'(CC_RST);
            bytes_reg      <= BYTES_W'(CHUNK_BYTES_RST);
            head_index_reg <= '0;
            head_run_reg   <= COUNT_W'(CC_RST);
            head_link_reg  <= {1'b1, {IDX_W{1'b0}}};
            free_reg       <= COUNT_W'(CC_RST);
            p95_reg        <= P95_W'(CC_RST * DANGER_PCT);
            p9_reg         <= P9_W'(CC_RST * SAFE_TENTHS);
            danger_thr_reg <= COUNT_W'(DNG_RST);
            safe_thr_reg   <= COUNT_W'(SAF_RST);
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            p95_reg        <= cc_reg * 7'd95;
            p9_reg         <= cc_reg * 4'd9;
            danger_thr_reg <= m100[SHIFT_100 +: COUNT_W];
            safe_thr_reg   <= m10[SHIFT_10 +: COUNT_W];

            if (cmd.exec)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cfg_we)
            begin
                case (cfg_index)
                    REG_CHUNK_COUNT:
                    begin
                        cc_reg         <= cc_wr;
                        head_index_reg <= '0;
                        head_run_reg   <= cc_wr;
                        head_link_reg  <= {1'b1, {IDX_W{1'b0}}};
                        free_reg       <= cc_wr;
                    end
                    REG_CHUNK_BYTES:
                    begin
                        bytes_reg <= cfg_data[BYTES_W-1:0];
                    end
                    default:
                    begin
                    end
                endcase
            end
            else if (cmd.exec)
            begin
                free_reg <= free_next;
                if (alloc_ok)
                begin
                    if (run_more)
                    begin
                        head_index_reg <= idx_step;
                        head_run_reg   <= run_eff - 1'b1;
                    end
                    else if (link_null)
                    begin
                        head_run_reg <= '0;
                    end
                end
                else if (free_ok)
                begin
                    head_index_reg <= fidx_reg;
                    head_run_reg   <= COUNT_W'(1);
                    head_link_reg  <= pool_empty ? {1'b1, {IDX_W{1'b0}}}
                                                 : {1'b0, head_index_reg};
                end
            end
            else if (cmd.load)
            begin
                // advance to the linked run fetched from the spill store
                head_index_reg <= head_link_reg[IDX_W-1:0];
                head_run_reg   <= ram_rdata[SPILL_W-1 -: COUNT_W] + 1'b1;
                head_link_reg  <= ram_rdata[LINK_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            func_reg <= req_func;
            fidx_reg <= req_free_index;
        end
        if (cmd.exec)
        begin
            out_reg <= res;
        end
    end

endmodule

>>> rtl/cpa_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Chunk pool allocator port checker
// Concurrent checks on the top level ports, attached by bind.
// ----------------------------------------------------------------------------
module cpa_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [cpa_pkg::CFG_ADDR_W-1:0] cfg_index,
    input  logic                           req_valid,
    input  logic                           req_ready,
    input  logic                           rsp_valid,
    input  logic                           rsp_ready,
    input  logic [cpa_pkg::STATUS_W-1:0]   rsp_status,
    input  logic [cpa_pkg::IDX_W-1:0]      rsp_chunk_index,
    input  logic [cpa_pkg::OFF_W-1:0]      rsp_chunk_offset,
    input  logic [cpa_pkg::COUNT_W-1:0]    rsp_free_count
);
    import cpa_pkg::*;

    // stalled response holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
            && $stable(rsp_chunk_index) && $stable(rsp_free_count))
        else $error("response changed while stalled");

    // one request in flight: ready drops after each accepted transaction
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted back to back");

    // failed operations report no chunk
    a_no_chunk_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status != STATUS_OK |-> rsp_chunk_index == '0
            && rsp_chunk_offset == '0)
        else $error("chunk reported on failed operation");

    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status == STATUS_EMPTY |-> rsp_free_count == '0)
        else $error("empty status with free chunks");

    // thresholds settle after a pool reinit
    a_reinit_block: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we && cfg_index == REG_CHUNK_COUNT |=> !req_ready)
        else $error("request taken right after reinit");

endmodule

bind chunk_pool_allocator_top cpa_checker u_cpa_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .req_valid        (req.valid),
    .req_ready        (req.ready),
    .rsp_valid        (rsp.valid),
    .rsp_ready        (rsp.ready),
    .rsp_status       (rsp.status),
    .rsp_chunk_index  (rsp.chunk_index),
    .rsp_chunk_offset (rsp.chunk_offset),
    .rsp_free_count   (rsp.free_count)
);
